### rtl/bsidw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsidw_pkg
// Shared types and constants of the blend-space inverse-distance weight core.
// ----------------------------------------------------------------------------
package bsidw_pkg;

  localparam int MaxSamples = 16;
  localparam int IdxW       = $clog2(MaxSamples);
  localparam int CntW       = IdxW + 1;
  localparam int CoordW     = 16;
  localparam int SqW        = 2 * (CoordW + 1);
  localparam int InvW       = 24;
  localparam int SumW       = InvW + IdxW;
  localparam int DivNumW    = InvW + 16;
  localparam int StepW      = $clog2(DivNumW + 1);
  localparam int RootStepW  = $clog2(SqW / 2 + 1);
  localparam int WeightW    = 17;
  localparam int CfgIdxW    = 3;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_EVAL   = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EMPTY_CLIP = 3'd1,
    ST_DUPLICATE  = 3'd2,
    ST_FULL       = 3'd3,
    ST_NOT_FOUND  = 3'd4,
    ST_NO_WEIGHTS = 3'd5
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TWO_D_MODE  = 3'd0,
    CFG_AXIS_LOW_X  = 3'd1,
    CFG_AXIS_HIGH_X = 3'd2,
    CFG_AXIS_LOW_Y  = 3'd3,
    CFG_AXIS_HIGH_Y = 3'd4,
    CFG_EXACT_THR   = 3'd5
  } cfg_index_t;

  localparam logic [DivNumW-1:0] InvNumerator = DivNumW'(1) << (DivNumW - 1);
  localparam logic [StepW-1:0]   InvSteps     = StepW'(InvW);
  localparam logic [StepW-1:0]   WeightSteps  = StepW'(DivNumW);

endpackage

### rtl/blend_space_idw_weights_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blend_space_idw_weights_core
// Sample table with add/remove and Shepard inverse-distance weight evaluation.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready and carry opcode, clip_id, pos_x, pos_y.
// Results leave on out_valid/out_ready as status, clip_out, weight, last.
// Registers are written on cfg_valid/cfg_ready (always ready) by cfg_index.
// One request is worked at a time; in_ready is high only while idle.
// Add and remove scan the table one entry a cycle, remove then moves later
// entries down one a cycle; each gives a single result.
// Evaluate runs per sample: square (one shared multiplier), compare with the
// exact threshold, a 17-step bit-pair square root and a 24-step restoring
// division for the inverse. Each weight then takes a 40-step pass of
// the same divider plus load, output and handshake. A full table holds
// 16 samples. The divider is the dominant unit.
// A stalled receiver holds the result register and the sequencer waits.
// Reset empties the table and restores the register defaults; the table
// contents themselves are not cleared, entries are written before use.
// ----------------------------------------------------------------------------
module blend_space_idw_weights_core
  import bsidw_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               opcode,
  input  logic [15:0]              clip_id,
  input  logic signed [CoordW-1:0] pos_x,
  input  logic signed [CoordW-1:0] pos_y,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2:0]               status,
  output logic [15:0]              clip_out,
  output logic [WeightW-1:0]       weight,
  output logic                     last,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CfgIdxW-1:0]       cfg_index,
  input  logic [15:0]              cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SHIFT, S_SQX, S_SQY, S_CHK, S_ROOT, S_DIV, S_STORE,
    S_WLOAD, S_WOUT, S_RESP
  } state_t;

  state_t state;

  // configuration
  logic                     two_d_mode;
  logic signed [CoordW-1:0] axis_low_x, axis_high_x, axis_low_y, axis_high_y;
  logic [15:0]              exact_threshold;

  // table
  logic [15:0]              entry_clip [MaxSamples];
  logic signed [CoordW-1:0] entry_x    [MaxSamples];
  logic signed [CoordW-1:0] entry_y    [MaxSamples];
  logic [InvW-1:0]          inverse_store [MaxSamples];
  logic [CntW-1:0]          entry_count;

  // request and working registers
  logic [1:0]               op;
  logic [15:0]              clip;
  logic signed [CoordW-1:0] qx, qy;
  logic [CntW-1:0]          idx;
  logic [SqW-1:0]           d2;
  logic [SqW-1:0]           rad;
  logic [SqW-1:0]           root;
  logic [RootStepW-1:0]     rstep;
  logic [DivNumW-1:0]       num;
  logic [SumW-1:0]          rem;
  logic [SumW-1:0]          divisor;
  logic [StepW-1:0]         dstep;
  logic                     div_weight;
  logic [SumW-1:0]          sum;
  logic                     more;

  // single table read port
  logic [IdxW-1:0]          rd_addr;
  logic [15:0]              rd_clip;
  logic signed [CoordW-1:0] rd_x, rd_y;
  logic [CntW-1:0]          idx_inc;

  assign idx_inc = idx + CntW'(1);
  assign rd_addr = (state == S_SHIFT) ? idx_inc[IdxW-1:0] : idx[IdxW-1:0];
  assign rd_clip = entry_clip[rd_addr];
  assign rd_x    = entry_x[rd_addr];
  assign rd_y    = entry_y[rd_addr];

  // input clamp, bounds ordered here
  logic signed [CoordW-1:0] lox, hix, loy, hiy, cx, cy;
  always_comb begin
    lox = (axis_low_x < axis_high_x) ? axis_low_x : axis_high_x;
    hix = (axis_low_x < axis_high_x) ? axis_high_x : axis_low_x;
    loy = (axis_low_y < axis_high_y) ? axis_low_y : axis_high_y;
    hiy = (axis_low_y < axis_high_y) ? axis_high_y : axis_low_y;
    cx  = (pos_x < lox) ? lox : ((pos_x > hix) ? hix : pos_x);
    cy  = (pos_y < loy) ? loy : ((pos_y > hiy) ? hiy : pos_y);
  end

  // shared squaring multiplier
  logic signed [CoordW:0] diff;
  logic [CoordW:0]        mag;
  logic [SqW-1:0]         sq;
  always_comb begin
    if (state == S_SQY) begin
      diff = (CoordW+1)'(qy) - (CoordW+1)'(rd_y);
    end else begin
      diff = (CoordW+1)'(qx) - (CoordW+1)'(rd_x);
    end
    mag = diff[CoordW] ? (CoordW+1)'(-diff) : diff;
    sq  = SqW'(mag) * SqW'(mag);
  end

  // root step
  logic [SqW-1:0] rbit, rtry;
  assign rbit = SqW'(1) << {rstep, 1'b0};
  assign rtry = root + rbit;

  // divider step, the inverse pass divides by the finished root directly
  logic [SumW-1:0] dvs;
  logic [SumW:0]   rem_t;
  logic            rem_ge;
  assign dvs    = div_weight ? divisor : SumW'(root);
  assign rem_t  = {rem, num[DivNumW-1]};
  assign rem_ge = rem_t >= {1'b0, dvs};

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_RESP);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      entry_count     <= '0;
      two_d_mode      <= 1'b1;
      axis_low_x      <= 16'sh8000;
      axis_high_x     <= 16'sh7FFF;
      axis_low_y      <= 16'sh8000;
      axis_high_y     <= 16'sh7FFF;
      exact_threshold <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_TWO_D_MODE:  two_d_mode      <= cfg_data[0];
          CFG_AXIS_LOW_X:  axis_low_x      <= cfg_data;
          CFG_AXIS_HIGH_X: axis_high_x     <= cfg_data;
          CFG_AXIS_LOW_Y:  axis_low_y      <= cfg_data;
          CFG_AXIS_HIGH_Y: axis_high_y     <= cfg_data;
          CFG_EXACT_THR:   exact_threshold <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op       <= opcode;
            clip     <= clip_id;
            idx      <= '0;
            sum      <= '0;
            more     <= 1'b0;
            last     <= 1'b1;
            weight   <= '0;
            clip_out <= clip_id;
            case (opcode)
              OP_ADD: begin
                qx <= pos_x;
                qy <= pos_y;
                if (clip_id == 16'd0) begin
                  status <= ST_EMPTY_CLIP;
                  state  <= S_RESP;
                end else begin
                  state <= S_SCAN;
                end
              end
              OP_REMOVE: state <= S_SCAN;
              OP_EVAL: begin
                qx <= cx;
                qy <= cy;
                if (entry_count == '0) begin
                  status   <= ST_NO_WEIGHTS;
                  clip_out <= '0;
                  state    <= S_RESP;
                end else begin
                  state <= S_SQX;
                end
              end
              default: ;
            endcase
          end
        end

        S_SCAN: begin
          if (idx == entry_count) begin
            if (op == OP_ADD) begin
              if (entry_count >= CntW'(MaxSamples)) begin
                status <= ST_FULL;
              end else begin
                entry_clip[entry_count[IdxW-1:0]] <= clip;
                entry_x[entry_count[IdxW-1:0]]    <= qx;
                entry_y[entry_count[IdxW-1:0]]    <= qy;
                entry_count <= entry_count + CntW'(1);
                status      <= ST_OK;
              end
            end else begin
              status <= ST_NOT_FOUND;
            end
            state <= S_RESP;
          end else if (rd_clip == clip) begin
            if (op == OP_ADD) begin
              status <= ST_DUPLICATE;
              state  <= S_RESP;
            end else begin
              state <= S_SHIFT;
            end
          end else begin
            idx <= idx_inc;
          end
        end

        S_SHIFT: begin
          if (idx_inc < entry_count) begin
            entry_clip[idx[IdxW-1:0]] <= rd_clip;
            entry_x[idx[IdxW-1:0]]    <= rd_x;
            entry_y[idx[IdxW-1:0]]    <= rd_y;
            idx <= idx_inc;
          end else begin
            entry_count <= entry_count - CntW'(1);
            status      <= ST_OK;
            state       <= S_RESP;
          end
        end

        S_SQX: begin
          d2    <= sq;
          state <= S_SQY;
        end

        S_SQY: begin
          if (two_d_mode) begin
            d2 <= d2 + sq;
          end
          state <= S_CHK;
        end

        S_CHK: begin
          if (d2 <= SqW'(exact_threshold)) begin
            status   <= ST_OK;
            clip_out <= rd_clip;
            weight   <= WeightW'(1) << 16;
            state    <= S_RESP;
          end else begin
            rad   <= d2;
            root  <= '0;
            rstep <= RootStepW'(SqW / 2 - 1);
            state <= S_ROOT;
          end
        end

        S_ROOT: begin
          if (rad >= rtry) begin
            rad  <= rad - rtry;
            root <= (root >> 1) + rbit;
          end else begin
            root <= root >> 1;
          end
          if (rstep == '0) begin
            num        <= InvNumerator;
            rem        <= '0;
            dstep      <= InvSteps;
            div_weight <= 1'b0;
            state      <= S_DIV;
          end else begin
            rstep <= rstep - RootStepW'(1);
          end
        end

        S_DIV: begin
          if (rem_ge) begin
            rem <= SumW'(rem_t - {1'b0, dvs});
            num <= {num[DivNumW-2:0], 1'b1};
          end else begin
            rem <= rem_t[SumW-1:0];
            num <= {num[DivNumW-2:0], 1'b0};
          end
          dstep <= dstep - StepW'(1);
          if (dstep == StepW'(1)) begin
            state <= div_weight ? S_WOUT : S_STORE;
          end
        end

        S_STORE: begin
          inverse_store[idx[IdxW-1:0]] <= num[InvW-1:0];
          sum <= sum + SumW'(num[InvW-1:0]);
          if (idx_inc == entry_count) begin
            idx   <= '0;
            state <= S_WLOAD;
          end else begin
            idx   <= idx_inc;
            state <= S_SQX;
          end
        end

        S_WLOAD: begin
          if (sum == '0) begin
            status   <= ST_NO_WEIGHTS;
            clip_out <= '0;
            state    <= S_RESP;
          end else begin
            num        <= {inverse_store[idx[IdxW-1:0]], 16'd0};
            rem        <= '0;
            divisor    <= sum;
            dstep      <= WeightSteps;
            div_weight <= 1'b1;
            state      <= S_DIV;
          end
        end

        S_WOUT: begin
          status   <= ST_OK;
          clip_out <= rd_clip;
          weight   <= num[WeightW-1:0];
          last     <= (idx_inc == entry_count);
          more     <= (idx_inc != entry_count);
          state    <= S_RESP;
        end

        S_RESP: begin
          if (out_ready) begin
            if (more) begin
              idx   <= idx_inc;
              state <= S_WLOAD;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CntW'(MaxSamples))
    else $error("entry count beyond table size");

  a_no_weights_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NO_WEIGHTS) |-> last && (weight == '0) && (clip_out == '0))
    else $error("no-weights result malformed");

  a_weight_le_one: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> weight <= (WeightW'(1) << 16))
    else $error("weight above one");

  a_bad_op_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (opcode == OP_UNUSED) |=> in_ready)
    else $error("unused opcode started work");

endmodule

### tb/sv/tb_blend_space_idw_weights_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_blend_space_idw_weights_core
// Self-checking bench for the blend-space inverse-distance weight core: a
// table model predicts every result of add, remove and evaluate requests under
// several register settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_blend_space_idw_weights_core
  import bsidw_pkg::*;
();

  localparam int LimitCycles = 4000000;
  localparam int SettleCycles = 64;

  typedef struct {
    status_t     st;
    logic [15:0] clip;
    logic [16:0] wgt;
    logic        fin;
  } weight_result_t;

  class weight_scoreboard;
    weight_result_t owed_results[$];
    int errors;
    logic two_d;
    int lo_x, hi_x, lo_y, hi_y;
    longint unsigned thr;
    logic [15:0] tab_clip[MaxSamples];
    int tab_x[MaxSamples];
    int tab_y[MaxSamples];
    int count;

    function new();
      errors = 0;
      count = 0;
      two_d = 1'b1;
      lo_x = -32768; hi_x = 32767; lo_y = -32768; hi_y = 32767;
      thr = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void set_reg(cfg_index_t idx, logic [15:0] val);
      case (idx)
        CFG_TWO_D_MODE:  two_d = val[0];
        CFG_AXIS_LOW_X:  lo_x = $signed(val);
        CFG_AXIS_HIGH_X: hi_x = $signed(val);
        CFG_AXIS_LOW_Y:  lo_y = $signed(val);
        CFG_AXIS_HIGH_Y: hi_y = $signed(val);
        CFG_EXACT_THR:   thr = val;
        default: ;
      endcase
    endfunction

    function int find_clip(logic [15:0] c);
      for (int i = 0; i < count; i++) if (tab_clip[i] == c) return i;
      return -1;
    endfunction

    function void owe(status_t st, logic [15:0] c, logic [16:0] w, logic f);
      weight_result_t r;
      r.st = st; r.clip = c; r.wgt = w; r.fin = f;
      owed_results.insert(owed_results.size(), r);
    endfunction

    function longint unsigned int_root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function int clamp(int v, int a, int b);
      int lo, hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void note_request(logic [1:0] op, logic [15:0] c, int px, int py);
      int at, qx, qy;
      longint signed dx, dy;
      longint unsigned d2, sum;
      longint unsigned inv[MaxSamples];
      case (op)
        OP_ADD: begin
          if (c == 0) owe(ST_EMPTY_CLIP, c, 0, 1);
          else if (find_clip(c) >= 0) owe(ST_DUPLICATE, c, 0, 1);
          else if (count >= MaxSamples) owe(ST_FULL, c, 0, 1);
          else begin
            tab_clip[count] = c; tab_x[count] = px; tab_y[count] = py;
            count++;
            owe(ST_OK, c, 0, 1);
          end
        end
        OP_REMOVE: begin
          at = find_clip(c);
          if (at < 0) owe(ST_NOT_FOUND, c, 0, 1);
          else begin
            for (int i = at; i + 1 < count; i++) begin
              tab_clip[i] = tab_clip[i+1]; tab_x[i] = tab_x[i+1]; tab_y[i] = tab_y[i+1];
            end
            count--;
            owe(ST_OK, c, 0, 1);
          end
        end
        OP_EVAL: begin
          if (count == 0) begin
            owe(ST_NO_WEIGHTS, 0, 0, 1);
            return;
          end
          qx = clamp(px, lo_x, hi_x);
          qy = clamp(py, lo_y, hi_y);
          sum = 0;
          for (int i = 0; i < count; i++) begin
            dx = qx - tab_x[i];
            dy = qy - tab_y[i];
            d2 = dx * dx;
            if (two_d) d2 += dy * dy;
            if (d2 <= thr) begin
              owe(ST_OK, tab_clip[i], 17'h10000, 1);
              return;
            end
            inv[i] = ((64'd1 << 23) / int_root(d2)) & 64'hFFFFFF;
            sum += inv[i];
          end
          if (sum == 0) begin
            owe(ST_NO_WEIGHTS, 0, 0, 1);
            return;
          end
          for (int i = 0; i < count; i++)
            owe(ST_OK, tab_clip[i], 17'((inv[i] << 16) / sum), i + 1 == count);
        end
        default: ;  // unused opcode gives nothing
      endcase
    endfunction

    task check_result(logic [2:0] st, logic [15:0] c, logic [16:0] w, logic f);
      weight_result_t r;
      if (owed_results.size() == 0) begin
        report($sformatf("unexpected result st=%0d clip=%0d w=%0d", st, c, w));
        return;
      end
      r = owed_results.pop_front();
      if (st != r.st) report($sformatf("status %0d, want %0d", st, r.st));
      if (c != r.clip) report($sformatf("clip_out %0d, want %0d", c, r.clip));
      if (w != r.wgt) report($sformatf("weight %0d, want %0d (clip %0d)", w, r.wgt, r.clip));
      if (f != r.fin) report($sformatf("last %0d, want %0d", f, r.fin));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] opcode = '0;
  logic [15:0] clip_id = '0;
  logic signed [CoordW-1:0] pos_x = '0;
  logic signed [CoordW-1:0] pos_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] status;
  logic [15:0] clip_out;
  logic [WeightW-1:0] weight;
  logic last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  weight_scoreboard sb = new();
  bit calm = 0;
  int cycles = 0;

  // handshakes captured at the rising edge, acted on at the falling edge
  logic in_fire = 0, out_fire = 0, cfg_fire = 0;
  logic [1:0] cap_op;
  logic [15:0] cap_clip, cap_x, cap_y, cap_oclip;
  logic [2:0] cap_st;
  logic [16:0] cap_w;
  logic cap_last;

  blend_space_idw_weights_core u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LimitCycles) begin
      $display("TB_ERROR");
      $finish;
    end
    in_fire <= in_valid && in_ready && !rst;
    out_fire <= out_valid && out_ready && !rst;
    cfg_fire <= cfg_valid && cfg_ready && !rst;
    cap_op <= opcode; cap_clip <= clip_id; cap_x <= pos_x; cap_y <= pos_y;
    cap_st <= status; cap_oclip <= clip_out; cap_w <= weight; cap_last <= last;
  end

  always @(negedge clk) begin
    if (in_fire) sb.note_request(cap_op, cap_clip, $signed(cap_x), $signed(cap_y));
    if (out_fire) sb.check_result(cap_st, cap_oclip, cap_w, cap_last);
  end

  // result side: random stall before each result
  initial begin
    int n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      n = calm ? 0 : $urandom_range(0, 8);
      if (n > 0) begin
        out_ready = 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(negedge clk); while (!out_fire);
    end
  end

  task send_request(logic [1:0] op, logic [15:0] c, int x, int y);
    int n;
    n = calm ? 0 : $urandom_range(0, 8);
    if (n > 0) begin
      in_valid = 1'b0;
      repeat (n) @(negedge clk);
    end
    opcode = op; clip_id = c; pos_x = CoordW'(x); pos_y = CoordW'(y);
    in_valid = 1'b1;
    do @(negedge clk); while (!in_fire);
  endtask

  // one more falling edge so the last accepted request is already predicted
  task wait_idle();
    in_valid = 1'b0;
    @(negedge clk);
    while (sb.owed_results.size() != 0 || !in_ready) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task write_reg(cfg_index_t idx, logic [15:0] val);
    cfg_index = idx; cfg_data = val;
    cfg_valid = 1'b1;
    do @(negedge clk); while (!cfg_fire);
    sb.set_reg(idx, val);
    cfg_valid = 1'b0;
  endtask

  task write_all(logic md, int lx, int hx, int ly, int hy, int th);
    write_reg(CFG_TWO_D_MODE, {15'd0, md});
    write_reg(CFG_AXIS_LOW_X, 16'(lx));
    write_reg(CFG_AXIS_HIGH_X, 16'(hx));
    write_reg(CFG_AXIS_LOW_Y, 16'(ly));
    write_reg(CFG_AXIS_HIGH_Y, 16'(hy));
    write_reg(CFG_EXACT_THR, 16'(th));
  endtask

  function int rand_pos();
    if ($urandom_range(0, 9) < 3) return $signed(16'($urandom));
    return $urandom_range(0, 2000) - 1000;
  endfunction

  initial begin
    int r, k;
    logic [15:0] c;
    repeat (10) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed: table edges, every status, exact hit, coordinate extremes
    send_request(OP_EVAL, 0, 0, 0);
    send_request(OP_ADD, 0, 5, 5);
    send_request(OP_ADD, 1, -32768, -32768);
    send_request(OP_ADD, 1, 0, 0);
    send_request(OP_ADD, 16'hFFFF, 32767, 32767);
    send_request(OP_ADD, 2, 0, 0);
    send_request(OP_EVAL, 0, 0, 0);
    send_request(OP_EVAL, 0, 300, -300);
    send_request(OP_EVAL, 0, -32768, 32767);
    send_request(OP_REMOVE, 0, 0, 0);
    send_request(OP_REMOVE, 77, 0, 0);
    send_request(OP_REMOVE, 16'hFFFF, 0, 0);
    send_request(OP_UNUSED, 9, 9, 9);
    for (int i = 3; i <= 16; i++) send_request(OP_ADD, 16'(i), i * 97 - 700, 500 - i * 61);
    send_request(OP_ADD, 40, 1, 1);
    send_request(OP_EVAL, 0, 123, 45);
    send_request(OP_REMOVE, 8, 0, 0);
    send_request(OP_EVAL, 0, 32767, -32768);
    wait_idle();

    // random phases, each under its own register setting
    for (int ph = 0; ph < 7; ph++) begin
      calm = (ph == 3);
      case (ph)
        0: write_all(1, -32768, 32767, -32768, 32767, 0);
        1: write_all(0, 32767, -32768, 1000, -1000, 65535);
        2: write_all(1, 0, 0, 0, 0, 65535);
        default: write_all(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
                           ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3000));
      endcase
      k = 0;
      while (k < 64) begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          send_request(OP_UNUSED, 16'($urandom), $urandom, $urandom);
          continue;
        end
        if (r < 42) begin
          c = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
          send_request(OP_ADD, c, rand_pos(), rand_pos());
        end else if (r < 67) begin
          if (sb.count > 0 && $urandom_range(0, 4) != 0)
            c = sb.tab_clip[$urandom_range(0, sb.count - 1)];
          else
            c = 16'($urandom);
          send_request(OP_REMOVE, c, 0, 0);
        end else if (sb.count > 0 && $urandom_range(0, 3) == 0) begin
          // query on or near a sample, so the threshold decides
          r = $urandom_range(0, sb.count - 1);
          send_request(OP_EVAL, 16'($urandom), sb.tab_x[r] + $urandom_range(0, 4) - 2,
                       sb.tab_y[r] + $urandom_range(0, 4) - 2);
        end else begin
          send_request(OP_EVAL, 16'($urandom), rand_pos(), rand_pos());
        end
        k++;
      end
      wait_idle();
    end

    if (sb.owed_results.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.owed_results.size()));
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/bsidw_pkg.sv
rtl/blend_space_idw_weights_core.sv
tb/sv/tb_blend_space_idw_weights_core.sv
